[rtl/core/rmsmm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rmsmm_pkg;

  // Default sizing of the block.
  localparam int MAX_LENGTH_DEF  = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths.
  localparam int REG_W       = 12;
  localparam int Q8_W        = 24;
  localparam int COUNT_OUT_W = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int FRAC_BITS   = 8;
  localparam int VAR_FRAC    = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [REG_W-1:0] REGION_START_RST = 12'h000;
  localparam logic [REG_W-1:0] REGION_END_RST   = 12'hFFF;

  // Sequencer states of the result engine.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_A,
    S_MUL_B,
    S_DIV_MEAN,
    S_DIV_VAR,
    S_SQRT,
    S_DONE
  } back_state_t;

endpackage

`default_nettype wire

[rtl/core/rmsmm_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Sample stream channel.
interface rmsmm_in_if #(
  parameter int SAMPLE_BITS = rmsmm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// Result channel.
interface rmsmm_out_if #(
  parameter int SAMPLE_BITS = rmsmm_pkg::SAMPLE_BITS_DEF
);
  logic                                        valid;
  logic                                        ready;
  logic signed [rmsmm_pkg::Q8_W-1:0]           mean_q8;
  logic        [rmsmm_pkg::Q8_W-1:0]           stddev_q8;
  logic signed [SAMPLE_BITS-1:0]               min_value;
  logic signed [SAMPLE_BITS-1:0]               max_value;
  logic        [rmsmm_pkg::COUNT_OUT_W-1:0]    sample_count;
  logic                                        region_empty;

  modport source (output valid, output mean_q8, output stddev_q8, output min_value,
                  output max_value, output sample_count, output region_empty,
                  input ready);
  modport sink   (input valid, input mean_q8, input stddev_q8, input min_value,
                  input max_value, input sample_count, input region_empty,
                  output ready);
endinterface

// Configuration write channel.
interface rmsmm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rmsmm_pkg::CFG_IDX_W-1:0]   index;
  logic [rmsmm_pkg::REG_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/rmsmm_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module rmsmm_fifo
  import rmsmm_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  // Two-entry queue of finished vector totals.
  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       level_r;

  assign full     = (level_r == 2'd2);
  assign empty    = (level_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      level_r <= level_r + 2'd1;
      else if (pop && !push) level_r <= level_r - 2'd1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

[rtl/core/rmsmm_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rmsmm_front
  import rmsmm_pkg::*;
#(
  parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int CW    = $clog2(MAX_LENGTH + 1),
  localparam int SUM_W = SAMPLE_BITS + CW,
  localparam int SQ_W  = 2 * SAMPLE_BITS + CW,
  localparam int JOB_W = SUM_W + SQ_W + CW + 2 * SAMPLE_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rmsmm_in_if.sink         in_chan,
  rmsmm_cfg_if.sink        cfg_chan,
  output logic             push,
  output logic [JOB_W-1:0] push_data,
  input  wire logic        full
);

  localparam int CMP_W = (CW > REG_W) ? CW : REG_W;

  logic [REG_W-1:0]              start_r, end_r;
  logic [CW-1:0]                 pos_r, pos_nxt;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SQ_W-1:0]               sq_r, sq_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic signed [SAMPLE_BITS-1:0] min_r, min_nxt, max_r, max_nxt;
  logic                          seen_r, seen_nxt;
  logic                          incl, accept;
  logic signed [2*SAMPLE_BITS-1:0] prod;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = !full;
  assign accept         = in_chan.valid && !full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= REGION_START_RST;
      end_r   <= REGION_END_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_REGION_START: start_r <= cfg_chan.data;
        CFG_REGION_END:   end_r   <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // Region test and running totals including the current sample.
  always_comb begin
    incl = (pos_r < CW'(MAX_LENGTH)) &&
           (CMP_W'(pos_r) >= CMP_W'(start_r)) &&
           (CMP_W'(pos_r) <= CMP_W'(end_r));
    prod     = in_chan.sample * in_chan.sample;
    pos_nxt  = (pos_r < CW'(MAX_LENGTH)) ? pos_r + CW'(1) : pos_r;
    sum_nxt  = sum_r;
    sq_nxt   = sq_r;
    cnt_nxt  = cnt_r;
    min_nxt  = min_r;
    max_nxt  = max_r;
    seen_nxt = seen_r;
    if (incl) begin
      sum_nxt  = sum_r + SUM_W'(in_chan.sample);
      sq_nxt   = sq_r + SQ_W'($unsigned(prod));
      cnt_nxt  = cnt_r + CW'(1);
      min_nxt  = (!seen_r || in_chan.sample < min_r) ? in_chan.sample : min_r;
      max_nxt  = (!seen_r || in_chan.sample > max_r) ? in_chan.sample : max_r;
      seen_nxt = 1'b1;
    end
  end

  assign push      = accept && in_chan.last;
  assign push_data = {sum_nxt, sq_nxt, cnt_nxt, min_nxt, max_nxt};

  // Accumulator update; a vector end clears the totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= '0;
      sq_r   <= '0;
      cnt_r  <= '0;
      min_r  <= '0;
      max_r  <= '0;
      seen_r <= 1'b0;
    end else if (accept) begin
      if (in_chan.last) begin
        pos_r  <= '0;
        sum_r  <= '0;
        sq_r   <= '0;
        cnt_r  <= '0;
        min_r  <= '0;
        max_r  <= '0;
        seen_r <= 1'b0;
      end else begin
        pos_r  <= pos_nxt;
        sum_r  <= sum_nxt;
        sq_r   <= sq_nxt;
        cnt_r  <= cnt_nxt;
        min_r  <= min_nxt;
        max_r  <= max_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/rmsmm_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module rmsmm_back
  import rmsmm_pkg::*;
#(
  parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int CW    = $clog2(MAX_LENGTH + 1),
  localparam int SUM_W = SAMPLE_BITS + CW,
  localparam int SQ_W  = 2 * SAMPLE_BITS + CW,
  localparam int JOB_W = SUM_W + SQ_W + CW + 2 * SAMPLE_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  output logic                  pop,
  input  wire logic [JOB_W-1:0] pop_data,
  input  wire logic             empty,
  rmsmm_out_if.source           out_chan
);

  localparam int P_W    = 2 * SUM_W;
  localparam int D_W    = P_W + VAR_FRAC;
  localparam int DEN_W  = 2 * CW;
  localparam int Q_W    = 2 * SAMPLE_BITS + VAR_FRAC;
  localparam int RT_W   = Q_W / 2;
  localparam int STEP_W = $clog2(D_W + 1);

  back_state_t state_r, state_nxt;

  // Fields of the queued vector totals.
  logic signed [SUM_W-1:0]       j_sum;
  logic [SQ_W-1:0]               j_sq;
  logic [CW-1:0]                 j_cnt;
  logic signed [SAMPLE_BITS-1:0] j_min, j_max;
  assign {j_sum, j_sq, j_cnt, j_min, j_max} = pop_data;

  logic [CW-1:0]           cnt_r;
  logic [SUM_W-1:0]        abs_r;
  logic                    neg_r;
  logic [P_W-1:0]          a_r, acc_r, cand_r, acc_add;
  logic [SUM_W-1:0]        plr_r;
  logic [STEP_W-1:0]       step_r;
  logic                    step_last;
  logic [D_W-1:0]          num_r, num_step;
  logic [DEN_W-1:0]        den_r, rem_r, rem_step;
  logic [DEN_W:0]          rem_t;
  logic                    div_ge;
  logic [Q_W-1:0]          rad_r;
  logic [RT_W+1:0]         srem_r, srem_step;
  logic [RT_W+3:0]         srem_t, trial;
  logic                    sq_ge;
  logic [RT_W-1:0]         root_r, root_step;
  logic [D_W:0]            mean_full;
  logic [P_W-1:0]          diff;

  logic signed [Q8_W-1:0]        mean_r;
  logic [Q8_W-1:0]               sd_r;
  logic signed [SAMPLE_BITS-1:0] omin_r, omax_r;
  logic [COUNT_OUT_W-1:0]        ocnt_r;
  logic                          oempty_r;

  // Step counter end for the unit that is running.
  always_comb begin
    case (state_r)
      S_MUL_A, S_MUL_B:      step_last = (step_r == STEP_W'(SUM_W - 1));
      S_DIV_MEAN, S_DIV_VAR: step_last = (step_r == STEP_W'(D_W - 1));
      S_SQRT:                step_last = (step_r == STEP_W'(RT_W - 1));
      default:               step_last = 1'b0;
    endcase
  end

  // One shift-add, one restoring-divide and one root step per cycle.
  always_comb begin
    acc_add   = plr_r[0] ? acc_r + cand_r : acc_r;
    rem_t     = {rem_r, num_r[D_W-1]};
    div_ge    = rem_t >= {1'b0, den_r};
    rem_step  = div_ge ? DEN_W'(rem_t - {1'b0, den_r}) : DEN_W'(rem_t);
    num_step  = {num_r[D_W-2:0], div_ge};
    srem_t    = {srem_r, rad_r[Q_W-1:Q_W-2]};
    trial     = (RT_W+4)'({root_r, 2'b01});
    sq_ge     = srem_t >= trial;
    srem_step = sq_ge ? (RT_W+2)'(srem_t - trial) : (RT_W+2)'(srem_t);
    root_step = {root_r[RT_W-2:0], sq_ge};
    mean_full = neg_r ? -{1'b0, num_step} : {1'b0, num_step};
    diff      = (a_r > acc_add) ? a_r - acc_add : '0;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (!empty) state_nxt = (j_cnt == '0) ? S_DONE : S_MUL_A;
      S_MUL_A:    if (step_last) state_nxt = S_MUL_B;
      S_MUL_B:    if (step_last) state_nxt = S_DIV_MEAN;
      S_DIV_MEAN: if (step_last) state_nxt = S_DIV_VAR;
      S_DIV_VAR:  if (step_last) state_nxt = S_SQRT;
      S_SQRT:     if (step_last) state_nxt = S_DONE;
      S_DONE:     if (out_chan.ready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    pop            = (state_r == S_IDLE) && !empty;
    out_chan.valid = (state_r == S_DONE);
  end

  assign out_chan.mean_q8      = mean_r;
  assign out_chan.stddev_q8    = sd_r;
  assign out_chan.min_value    = omin_r;
  assign out_chan.max_value    = omax_r;
  assign out_chan.sample_count = ocnt_r;
  assign out_chan.region_empty = oempty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Datapath sequence: n*sumsq, sum^2, mean divide, variance divide, root.
  always_ff @(posedge clk) begin
    step_r <= step_last ? '0 : step_r + STEP_W'(1);
    case (state_r)
      S_IDLE: begin
        step_r   <= '0;
        cnt_r    <= j_cnt;
        neg_r    <= j_sum < 0;
        abs_r    <= (j_sum < 0) ? SUM_W'(-j_sum) : SUM_W'(j_sum);
        acc_r    <= '0;
        cand_r   <= P_W'(j_sq);
        plr_r    <= SUM_W'(j_cnt);
        omin_r   <= j_min;
        omax_r   <= j_max;
        ocnt_r   <= COUNT_OUT_W'(j_cnt);
        oempty_r <= (j_cnt == '0);
        mean_r   <= '0;
        sd_r     <= '0;
      end
      S_MUL_A: begin
        acc_r  <= acc_add;
        cand_r <= cand_r << 1;
        plr_r  <= plr_r >> 1;
        if (step_last) begin
          a_r    <= acc_add;
          acc_r  <= '0;
          cand_r <= P_W'(abs_r);
          plr_r  <= abs_r;
        end
      end
      S_MUL_B: begin
        acc_r  <= acc_add;
        cand_r <= cand_r << 1;
        plr_r  <= plr_r >> 1;
        if (step_last) begin
          a_r   <= diff;
          num_r <= D_W'({abs_r, {FRAC_BITS{1'b0}}});
          den_r <= DEN_W'(cnt_r);
          rem_r <= '0;
        end
      end
      S_DIV_MEAN: begin
        num_r <= num_step;
        rem_r <= rem_step;
        if (step_last) begin
          mean_r <= Q8_W'(mean_full);
          num_r  <= {a_r, {VAR_FRAC{1'b0}}};
          den_r  <= cnt_r * cnt_r;
          rem_r  <= '0;
        end
      end
      S_DIV_VAR: begin
        num_r <= num_step;
        rem_r <= rem_step;
        if (step_last) begin
          rad_r  <= num_step[Q_W-1:0];
          srem_r <= '0;
          root_r <= '0;
        end
      end
      S_SQRT: begin
        rad_r  <= rad_r << 2;
        srem_r <= srem_step;
        root_r <= root_step;
        if (step_last) sd_r <= Q8_W'(root_step);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/region_mean_stddev_min_max_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one item per cycle while the queue is not full; each vector end costs one pass
// of the iterative result engine (shift-add multiply, restoring divide, bit-pair root), and a
// two-entry queue lets the front keep accepting items while that engine works.
// Reset: synchronous, active low; registers take region 0..4095 and all totals clear.
module region_mean_stddev_min_max_core
  import rmsmm_pkg::*;
#(
  parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rmsmm_in_if.sink    in_chan,
  rmsmm_out_if.source out_chan,
  rmsmm_cfg_if.sink   cfg_chan
);

  localparam int CW    = $clog2(MAX_LENGTH + 1);
  localparam int SUM_W = SAMPLE_BITS + CW;
  localparam int SQ_W  = 2 * SAMPLE_BITS + CW;
  localparam int JOB_W = SUM_W + SQ_W + CW + 2 * SAMPLE_BITS;

  logic             push, full, pop, empty;
  logic [JOB_W-1:0] push_data, pop_data;

  // Sample intake and accumulation.
  rmsmm_front #(
    .MAX_LENGTH  (MAX_LENGTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg_chan  (cfg_chan),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // Queue of finished vector totals.
  rmsmm_fifo #(
    .WIDTH (JOB_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // Mean, deviation and result register.
  rmsmm_back #(
    .MAX_LENGTH  (MAX_LENGTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (empty),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

[tb/sv/tb_region_mean_stddev_min_max_core.sv]
`timescale 1ns / 1ps

module tb_region_mean_stddev_min_max_core;
  import rmsmm_pkg::*;

  localparam int SB        = SAMPLE_BITS_DEF;
  localparam int MAXLEN    = MAX_LENGTH_DEF;
  localparam int DRAIN     = 300;
  localparam int LIMIT     = 1000000;
  localparam int RAND_ITEMS = 550;
  localparam int HOLD_LEN  = 1500;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct {
    logic signed [Q8_W-1:0]        mean_q8;
    logic        [Q8_W-1:0]        stddev_q8;
    logic signed [SB-1:0]          min_value;
    logic signed [SB-1:0]          max_value;
    logic        [COUNT_OUT_W-1:0] sample_count;
    logic                          region_empty;
  } stats_t;

  typedef enum {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [REG_W-1:0]      data;
    logic signed [SB-1:0]  sample;
    logic                  last;
    bit                    typed;
    stats_t                res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rmsmm_in_if  #(.SAMPLE_BITS(SB)) in_chan ();
  rmsmm_out_if #(.SAMPLE_BITS(SB)) out_chan ();
  rmsmm_cfg_if                     cfg_chan ();

  region_mean_stddev_min_max_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source),
    .cfg_chan(cfg_chan.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block: region registers and per-vector totals.
  logic [REG_W-1:0] m_start;
  logic [REG_W-1:0] m_end;
  int               m_pos;
  longint           m_sum;
  longint unsigned  m_sum_sq;
  longint unsigned  m_count;
  longint           m_min;
  longint           m_max;
  bit               m_seen;

  stats_t stats_q[$];
  row_t   rows[$];
  int     errors = 0;
  int     results_seen = 0;
  int     cycles = 0;
  int     items_sent = 0;

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= root + b) begin
        x = x - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic void clear_totals();
    m_pos = 0;
    m_sum = 0;
    m_sum_sq = 0;
    m_count = 0;
    m_min = 0;
    m_max = 0;
    m_seen = 0;
  endfunction

  // Accumulates one accepted item; returns 1 with the statistics on a vector end.
  function automatic bit accumulate_sample(input logic signed [SB-1:0] s, input logic lst,
                                           output stats_t r);
    longint          v;
    longint          mean;
    longint unsigned abs_sum, d, a, b, nn, q, rem, var_q16;
    v = s;
    if (m_pos < MAXLEN && m_pos >= m_start && m_pos <= m_end) begin
      m_sum += v;
      m_sum_sq += longint'(v * v);
      m_count++;
      if (!m_seen || v < m_min) m_min = v;
      if (!m_seen || v > m_max) m_max = v;
      m_seen = 1;
    end
    if (m_pos < MAXLEN) m_pos++;
    if (!lst) return 0;
    if (m_count == 0) begin
      r.mean_q8 = '0;
      r.stddev_q8 = '0;
      r.min_value = '0;
      r.max_value = '0;
      r.sample_count = '0;
      r.region_empty = 1'b1;
    end else begin
      mean = (m_sum * 256) / longint'(m_count);
      abs_sum = m_sum < 0 ? -m_sum : m_sum;
      a = m_count * m_sum_sq;
      b = abs_sum * abs_sum;
      d = a > b ? a - b : 0;
      nn = m_count * m_count;
      q = d / nn;
      rem = d % nn;
      var_q16 = q * 65536 + (rem * 65536) / nn;
      r.mean_q8 = mean[Q8_W-1:0];
      r.stddev_q8 = Q8_W'(int_sqrt(var_q16));
      r.min_value = m_min[SB-1:0];
      r.max_value = m_max[SB-1:0];
      r.sample_count = m_count[COUNT_OUT_W-1:0];
      r.region_empty = 1'b0;
    end
    clear_totals();
    return 1;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    int p;
    p = $urandom_range(0, 99);
    if (p < 10) return 16'sh7FFF;
    if (p < 20) return 16'sh8000;
    if (p < 50) return SB'($urandom_range(0, 200) - 100);
    return SB'($urandom);
  endfunction

  // Waits until every expected result is out and the result engine has settled.
  task automatic wait_idle();
    while (stats_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    do @(posedge clk); while (!cfg_chan.ready);
    case (idx)
      CFG_REGION_START: m_start = data;
      CFG_REGION_END:   m_end = data;
      default: ;
    endcase
    cfg_chan.valid <= 1'b0;
  endtask

  // Offers one item; the caller lowers valid when a gap follows.
  task automatic send_item(input logic signed [SB-1:0] s, input logic lst,
                           input bit typed, input stats_t typed_res);
    stats_t r;
    in_chan.valid  <= 1'b1;
    in_chan.sample <= s;
    in_chan.last   <= lst;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
    if (accumulate_sample(s, lst, r)) stats_q.push_back(typed ? typed_res : r);
  endtask

  task automatic send_gap();
    int g;
    g = gap_len();
    if (g != 0) begin
      in_chan.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_vector(input int len);
    stats_t none;
    for (int k = 0; k < len; k++) begin
      send_item(pick_sample(), k == len - 1, 0, none);
      send_gap();
    end
  endtask

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [REG_W-1:0] data);
    row_t r;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    r.typed = 0;
    rows.push_back(r);
  endfunction

  function automatic void add_item(input logic signed [SB-1:0] s, input logic lst);
    row_t r;
    r.kind = ROW_ITEM;
    r.sample = s;
    r.last = lst;
    r.typed = 0;
    rows.push_back(r);
  endfunction

  function automatic void add_item_exp(input logic signed [SB-1:0] s,
                                       input logic signed [Q8_W-1:0] mean,
                                       input logic signed [SB-1:0] mn,
                                       input logic signed [SB-1:0] mx,
                                       input int cnt, input logic empty);
    row_t r;
    r.kind = ROW_ITEM;
    r.sample = s;
    r.last = 1'b1;
    r.typed = 1;
    r.res.mean_q8 = mean;
    r.res.stddev_q8 = '0;
    r.res.min_value = mn;
    r.res.max_value = mx;
    r.res.sample_count = COUNT_OUT_W'(cnt);
    r.res.region_empty = empty;
    rows.push_back(r);
  endfunction

  // Result side: checks each accepted result and drives ready with random stalls.
  int hold_cnt = 0;
  bit hold_done = 0;
  int stall_cnt = 0;

  always @(posedge clk) begin
    stats_t e;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (stats_q.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        e = stats_q.pop_front();
        if (out_chan.mean_q8 !== e.mean_q8) begin
          $error("mean_q8 expected %0d got %0d", e.mean_q8, out_chan.mean_q8);
          errors++;
        end
        if (out_chan.stddev_q8 !== e.stddev_q8) begin
          $error("stddev_q8 expected %0d got %0d", e.stddev_q8, out_chan.stddev_q8);
          errors++;
        end
        if (out_chan.min_value !== e.min_value) begin
          $error("min_value expected %0d got %0d", e.min_value, out_chan.min_value);
          errors++;
        end
        if (out_chan.max_value !== e.max_value) begin
          $error("max_value expected %0d got %0d", e.max_value, out_chan.max_value);
          errors++;
        end
        if (out_chan.sample_count !== e.sample_count) begin
          $error("sample_count expected %0d got %0d", e.sample_count,
                 out_chan.sample_count);
          errors++;
        end
        if (out_chan.region_empty !== e.region_empty) begin
          $error("region_empty expected %0d got %0d", e.region_empty,
                 out_chan.region_empty);
          errors++;
        end
      end
    end
    // One long hold-off once traffic is flowing, so the block backs up.
    if (!hold_done && results_seen >= 20) begin
      hold_done = 1;
      hold_cnt = HOLD_LEN;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_chan.ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_chan.ready <= 1'b0;
    end else begin
      stall_cnt = (results_seen / 10) % 3 == 2 ? 0 : gap_len();
      out_chan.ready <= (stall_cnt == 0);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("region_mean_stddev_min_max_core regression: fail");
      $finish;
    end
  end

  initial begin
    logic [REG_W-1:0] a, b;
    int vec;
    in_chan.valid = 1'b0;
    in_chan.sample = '0;
    in_chan.last = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = CFG_REGION_START;
    cfg_chan.data = '0;
    out_chan.ready = 1'b0;
    m_start = REGION_START_RST;
    m_end = REGION_END_RST;
    clear_totals();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: extremes, empty regions, spare indexes.
    add_item_exp(16'sh7FFF, 24'sd8388352, 16'sh7FFF, 16'sh7FFF, 1, 1'b0);
    add_item_exp(16'sh8000, -24'sd8388608, 16'sh8000, 16'sh8000, 1, 1'b0);
    add_item(16'sh7FFF, 1'b0);
    add_item(16'sh8000, 1'b1);
    add_item(16'sh8000, 1'b0);
    add_item(16'sh8000, 1'b0);
    add_item(16'sh7FFF, 1'b1);
    add_cfg(CFG_REGION_START, 12'd5);
    add_cfg(CFG_REGION_END, 12'd2);
    add_item_exp(16'sd100, '0, '0, '0, 0, 1'b1);
    add_cfg(CFG_SPARE_A, 12'hABC);
    add_cfg(CFG_SPARE_B, 12'h555);
    add_cfg(CFG_REGION_START, 12'd3);
    add_cfg(CFG_REGION_END, 12'd3);
    add_item(16'sd7, 1'b0);
    add_item(-16'sd9, 1'b0);
    add_item_exp(16'sd11, '0, '0, '0, 0, 1'b1);
    add_item(16'sd1, 1'b0);
    add_item(16'sd2, 1'b0);
    add_item(16'sd3, 1'b0);
    add_item_exp(-16'sd4, -24'sd1024, -16'sd4, -16'sd4, 1, 1'b0);
    add_cfg(CFG_REGION_START, REGION_START_RST);
    add_cfg(CFG_REGION_END, REGION_END_RST);
    add_item(-16'sd3, 1'b0);
    add_item(16'sd1, 1'b1);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        in_chan.valid <= 1'b0;
        wait_idle();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_item(rows[i].sample, rows[i].last, rows[i].typed, rows[i].res);
        send_gap();
      end
    end

    // Random vectors, with the region changed every so often.
    vec = 0;
    while (items_sent < RAND_ITEMS) begin
      if (vec % 12 == 11) begin
        in_chan.valid <= 1'b0;
        wait_idle();
        case ($urandom_range(0, 7))
          0: begin a = '0;             b = REG_W'(4095); end
          1: begin a = REG_W'(4095);   b = REG_W'(4095); end
          2: begin a = '0;             b = '0;           end
          3: begin a = REG_W'(4095);   b = '0;           end
          default: begin
            a = REG_W'($urandom_range(0, 6));
            b = ($urandom_range(0, 4) == 0) ? REG_W'($urandom_range(0, 4))
                                            : a + REG_W'($urandom_range(0, 10));
          end
        endcase
        if ($urandom_range(0, 1)) begin
          write_reg(CFG_REGION_START, a);
          write_reg(CFG_REGION_END, b);
        end else begin
          write_reg(CFG_REGION_END, b);
          write_reg(CFG_REGION_START, a);
        end
        if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE_A, REG_W'($urandom));
      end
      // Sender pause until the block has drained.
      if (vec == 40) begin
        in_chan.valid <= 1'b0;
        while (stats_q.size() != 0) @(posedge clk);
      end
      send_vector($urandom_range(0, 99) < 85 ? $urandom_range(1, 12) : $urandom_range(13, 40));
      vec++;
    end

    in_chan.valid <= 1'b0;
    wait_idle();
    if (errors == 0) begin
      $display("region_mean_stddev_min_max_core regression: pass");
    end else begin
      $display("region_mean_stddev_min_max_core regression: fail");
    end
    $finish;
  end

endmodule
